// ----- sv/grcp_pkg.sv -----
// Shared constants and types for the guide relay command parser.
// No dependencies; the parser, executor and top files import this package.
package grcp_pkg;

  localparam int unsigned ValueW = 15;
  localparam logic [ValueW-1:0] ValueMax   = 15'd32767;
  localparam logic [ValueW-1:0] LimitReset = 15'd30000;

  // Character codes seen on the serial line
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChAllOff  = 8'h54; // 'T'
  localparam logic [7:0] ChNorthUp = 8'h4E; // 'N'
  localparam logic [7:0] ChEastUp  = 8'h45; // 'E'
  localparam logic [7:0] ChWestUp  = 8'h57; // 'W'
  localparam logic [7:0] ChSouthUp = 8'h53; // 'S'
  localparam logic [7:0] ChNorthLo = 8'h6E; // 'n'
  localparam logic [7:0] ChEastLo  = 8'h65; // 'e'
  localparam logic [7:0] ChWestLo  = 8'h77; // 'w'
  localparam logic [7:0] ChSouthLo = 8'h73; // 's'

  // Input beat command codes
  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Relay indexes, bit positions in the relay level vector
  localparam logic [1:0] RelayNorth = 2'd0;
  localparam logic [1:0] RelayEast  = 2'd1;
  localparam logic [1:0] RelayWest  = 2'd2;
  localparam logic [1:0] RelaySouth = 2'd3;

  // A completed line handed from the parser to the executor
  typedef struct packed {
    logic              done;
    logic [7:0]        letter;
    logic [ValueW-1:0] value;
  } line_t;

endpackage

// ----- sv/grcp_if.sv -----
// Valid/ready channel interfaces for the guide relay command parser.
// Depends on nothing; carries the input beat and the result beat.
interface grcp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface grcp_out_if;
  logic valid;
  logic ready;
  logic north_on;
  logic east_on;
  logic west_on;
  logic south_on;
  logic pulse_busy;
  logic value_scrapped;

  modport source (output valid, north_on, east_on, west_on, south_on, pulse_busy,
                  value_scrapped, input ready);
  modport sink   (input valid, north_on, east_on, west_on, south_on, pulse_busy,
                  value_scrapped, output ready);
endinterface

// ----- sv/grcp_parser.sv -----
// Line assembler: latches the command letter and accumulates decimal digits.
// Depends on grcp_pkg.
module grcp_parser
  import grcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en_i,
  input  logic [7:0] rx_byte_i,
  output line_t      line_o
);

  logic [7:0]        line_letter_r, line_letter_nxt;
  logic              line_open_r, line_open_nxt;
  logic [ValueW-1:0] digit_value_r, digit_value_nxt;
  logic              too_big_r, too_big_nxt;

  logic              is_digit;
  logic              is_newline;
  logic [ValueW+3:0] accum;

  assign is_digit   = (rx_byte_i >= ChZero) && (rx_byte_i <= ChNine);
  assign is_newline = (rx_byte_i == ChNewline);

  // Multiply by ten as two shifts, then add the digit
  assign accum = ({4'd0, digit_value_r} << 3) + ({4'd0, digit_value_r} << 1)
               + {{(ValueW){1'b0}}, rx_byte_i[3:0]};

  // Hand the finished line to the executor on newline
  always_comb begin
    line_o.done   = byte_en_i && is_newline;
    line_o.letter = line_open_r ? line_letter_r : rx_byte_i;
    line_o.value  = too_big_r ? ValueMax : digit_value_r;
  end

  // Advance the line state on each received byte
  always_comb begin
    line_letter_nxt = line_letter_r;
    line_open_nxt   = line_open_r;
    digit_value_nxt = digit_value_r;
    too_big_nxt     = too_big_r;
    if (byte_en_i) begin
      if (!line_open_r) begin
        line_letter_nxt = rx_byte_i;
        line_open_nxt   = 1'b1;
      end
      if (is_digit) begin
        if (too_big_r || (accum > {4'd0, ValueMax})) begin
          digit_value_nxt = ValueMax;
          too_big_nxt     = 1'b1;
        end else begin
          digit_value_nxt = accum[ValueW-1:0];
        end
      end
      if (is_newline) begin
        line_letter_nxt = '0;
        line_open_nxt   = 1'b0;
        digit_value_nxt = '0;
        too_big_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_letter_r <= '0;
      line_open_r   <= 1'b0;
      digit_value_r <= '0;
      too_big_r     <= 1'b0;
    end else begin
      line_letter_r <= line_letter_nxt;
      line_open_r   <= line_open_nxt;
      digit_value_r <= digit_value_nxt;
      too_big_r     <= too_big_nxt;
    end
  end

endmodule

// ----- sv/grcp_exec.sv -----
// Line executor: relay levels, pulse countdown and the one-line pending slot.
// Depends on grcp_pkg; fed by grcp_parser.
module grcp_exec
  import grcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_i,
  input  line_t             line_i,
  input  logic [ValueW-1:0] limit_i,
  output logic [3:0]        relays_o,
  output logic              busy_o,
  output logic              scrapped_o
);

  logic [3:0]        relays_r, relays_nxt;
  logic [ValueW-1:0] pulse_left_r, pulse_left_nxt;
  logic [1:0]        pulse_relay_r, pulse_relay_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [7:0]        pend_letter_r, pend_letter_nxt;
  logic [ValueW-1:0] pend_value_r, pend_value_nxt;
  logic              scrapped_r, scrapped_nxt;

  logic              busy;
  logic [ValueW-1:0] left_dec;
  logic              run_en;
  logic [7:0]        run_letter;
  logic [ValueW-1:0] run_value;
  logic              run_pulse;
  logic [1:0]        run_idx;
  logic              run_over;

  assign busy     = (pulse_left_r != '0);
  assign left_dec = pulse_left_r - {{(ValueW-1){1'b0}}, 1'b1};
  assign run_over = (run_value >= limit_i);

  always_comb begin
    relays_nxt      = relays_r;
    pulse_left_nxt  = pulse_left_r;
    pulse_relay_nxt = pulse_relay_r;
    pend_valid_nxt  = pend_valid_r;
    pend_letter_nxt = pend_letter_r;
    pend_value_nxt  = pend_value_r;
    scrapped_nxt    = scrapped_r;
    run_en          = 1'b0;
    run_letter      = line_i.letter;
    run_value       = line_i.value;
    run_pulse       = 1'b0;
    run_idx         = RelayNorth;

    // Count the pulse down; at its end drop the relay and release the pending line
    if (tick_i) begin
      if (busy) begin
        pulse_left_nxt = left_dec;
        if (left_dec == '0) begin
          relays_nxt[pulse_relay_r] = 1'b0;
          if (pend_valid_r) begin
            pend_valid_nxt = 1'b0;
            run_en         = 1'b1;
            run_letter     = pend_letter_r;
            run_value      = pend_value_r;
          end
        end
      end
    end else if (line_i.done) begin
      // Park a line during a pulse if the slot is free, else drop it; with no pulse, run it now
      if (busy) begin
        if (!pend_valid_r) begin
          pend_valid_nxt  = 1'b1;
          pend_letter_nxt = line_i.letter;
          pend_value_nxt  = line_i.value;
        end
      end else begin
        run_en = 1'b1;
      end
    end

    // Execute the selected line
    if (run_en) begin
      unique case (run_letter)
        ChNorthLo: relays_nxt = 4'b0001;
        ChEastLo:  relays_nxt = 4'b0010;
        ChWestLo:  relays_nxt = 4'b0100;
        ChSouthLo: relays_nxt = 4'b1000;
        ChAllOff:  relays_nxt = 4'b0000;
        ChNorthUp: begin run_pulse = 1'b1; run_idx = RelayNorth; end
        ChEastUp:  begin run_pulse = 1'b1; run_idx = RelayEast;  end
        ChWestUp:  begin run_pulse = 1'b1; run_idx = RelayWest;  end
        ChSouthUp: begin run_pulse = 1'b1; run_idx = RelaySouth; end
        default:   run_pulse = 1'b0;
      endcase
      if (run_pulse) begin
        scrapped_nxt = run_over;
        if (run_over || (run_value == '0)) begin
          relays_nxt[run_idx] = 1'b0;
        end else begin
          relays_nxt[run_idx] = 1'b1;
          pulse_left_nxt      = run_value;
          pulse_relay_nxt     = run_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relays_r      <= '0;
      pulse_left_r  <= '0;
      pulse_relay_r <= RelayNorth;
      pend_valid_r  <= 1'b0;
      pend_letter_r <= '0;
      pend_value_r  <= '0;
      scrapped_r    <= 1'b0;
    end else begin
      relays_r      <= relays_nxt;
      pulse_left_r  <= pulse_left_nxt;
      pulse_relay_r <= pulse_relay_nxt;
      pend_valid_r  <= pend_valid_nxt;
      pend_letter_r <= pend_letter_nxt;
      pend_value_r  <= pend_value_nxt;
      scrapped_r    <= scrapped_nxt;
    end
  end

  assign relays_o   = relays_r;
  assign busy_o     = busy;
  assign scrapped_o = scrapped_r;

  // The pulsed relay stays on for the whole countdown
  a_pulse_relay_on: assert property (@(posedge clk) disable iff (!rst_n)
    (pulse_left_r != '0) |-> relays_r[pulse_relay_r])
    else $error("pulsed relay off while pulse counts");

  // A line only waits while a pulse is running
  a_pend_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pulse_left_r != '0))
    else $error("pending line without running pulse");

  // The scrapped flag moves only on a tick or a finished line
  a_scrapped_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(tick_i || line_i.done) |=> $stable(scrapped_r))
    else $error("scrapped flag changed without a beat");

endmodule

// ----- sv/guide_relay_command_parser_top.sv -----
// Top level of the guide relay command parser: channel handshake, limit register.
// Depends on grcp_pkg, grcp_if, grcp_parser and grcp_exec.
//
// Each input beat (a serial byte or a millisecond tick) updates the parser and executor state, and a
// new beat is taken every cycle while the result side keeps up; the state registers
// that drive the relays double as the result register, so a result waits there until
// taken and the next beat is accepted in the same cycle the result leaves. The
// duration limit is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle (the block itself does not enforce this). The limit resets to 30000.
module guide_relay_command_parser_top
  import grcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  grcp_in_if.sink           in_ch,
  grcp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [ValueW-1:0] cfg_wdata
);

  logic              out_valid_r, out_valid_nxt;
  logic [ValueW-1:0] limit_r;
  logic              accept;
  line_t             line;
  logic [3:0]        relays;
  logic              busy;
  logic              scrapped;

  // Take a beat whenever the result slot is empty or being emptied, never in reset
  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      limit_r     <= LimitReset;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  grcp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en_i (accept && (in_ch.command == CmdByte)),
    .rx_byte_i (in_ch.rx_byte),
    .line_o    (line)
  );

  grcp_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_i     (accept && (in_ch.command == CmdTick)),
    .line_i     (line),
    .limit_i    (limit_r),
    .relays_o   (relays),
    .busy_o     (busy),
    .scrapped_o (scrapped)
  );

  // Drive the result beat straight from the executor state
  assign out_ch.valid          = out_valid_r;
  assign out_ch.north_on       = relays[RelayNorth];
  assign out_ch.east_on        = relays[RelayEast];
  assign out_ch.west_on        = relays[RelayWest];
  assign out_ch.south_on       = relays[RelaySouth];
  assign out_ch.pulse_busy     = busy;
  assign out_ch.value_scrapped = scrapped;

endmodule
